[hw/rtl/rpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

  localparam int unsigned MAX_POSITIONS = 2048;
  localparam int unsigned MAX_PAIRS     = 64;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned PAIR_W   = 6;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PAIRS_FIELD_W = 7;

  localparam int unsigned ROWS_RESET  = 2048;
  localparam int unsigned PAIRS_RESET = 64;

  // remainder pipeline: position bits resolved per stage
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = POS_W / DIV_BITS;

  // q1.14 rounding
  localparam int unsigned FRAC_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_ROWS   = 2'd0,
    CFG_ACTIVE_PAIRS = 2'd1,
    CFG_WRAP_MODE    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_ROTATE = 1'b1
  } req_e;

  typedef struct packed {
    req_e                    req_type;
    logic [POS_W-1:0]        position;
    logic [PAIR_W-1:0]       pair_index;
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic signed [VAL_W-1:0] cos_value;
    logic signed [VAL_W-1:0] sin_value;
    logic                    err;
    logic                    beyond;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/rpr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rpr_row_map.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpr_row_map #(
  parameter int unsigned MAX_POSITIONS = rpr_pkg::MAX_POSITIONS,
  parameter int unsigned MAX_PAIRS     = rpr_pkg::MAX_PAIRS,
  localparam int unsigned CNT_W  = $clog2(MAX_POSITIONS + 1),
  localparam int unsigned ROW_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
  localparam int unsigned DEPTH  = MAX_POSITIONS * MAX_PAIRS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CNT_W-1:0]  rows_i,
  input  wire logic              wrap_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rpr_pkg::item_t    in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rpr_pkg::item_t         out_item_o,
  output logic      [ADDR_W-1:0] out_addr_o
);

  localparam int unsigned NST = rpr_pkg::DIV_STAGES;
  localparam int unsigned DB  = rpr_pkg::DIV_BITS;
  localparam int unsigned PW  = rpr_pkg::POS_W;
  localparam logic [ADDR_W-1:0] PAIRS_C = ADDR_W'(MAX_PAIRS);

  // one restoring remainder step per position bit
  function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] rem,
                                                input logic [DB-1:0]    bits,
                                                input logic [CNT_W-1:0] rows);
    logic [CNT_W:0]   acc;
    logic [CNT_W-1:0] r;
    r = rem;
    for (int j = DB - 1; j >= 0; j--) begin
      acc = {r, bits[j]};
      if (acc >= {1'b0, rows}) begin
        acc = acc - {1'b0, rows};
      end
      r = acc[CNT_W-1:0];
    end
    return r;
  endfunction

  logic [NST:0]       en;
  logic [NST-1:0]     v_q;
  rpr_pkg::item_t     item_q [NST];
  logic [CNT_W-1:0]   rem_q  [NST];
  logic [NST-1:0]     pv;
  rpr_pkg::item_t     pitem  [NST];
  logic [CNT_W-1:0]   prem   [NST];

  logic               a_v_q;
  rpr_pkg::item_t     a_item_q;
  logic [ADDR_W-1:0]  a_addr_q;
  logic [ADDR_W-1:0]  a_addr_d;
  logic [ROW_W-1:0]   row;
  logic [CNT_W-1:0]   rows_m1;

  for (genvar k = 0; k < NST; k++) begin : g_div
    if (k == 0) begin : g_first
      assign pv[k]    = in_valid_i;
      assign pitem[k] = in_item_i;
      assign prem[k]  = '0;
    end else begin : g_next
      assign pv[k]    = v_q[k-1];
      assign pitem[k] = item_q[k-1];
      assign prem[k]  = rem_q[k-1];
    end

    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && pv[k]) begin
        item_q[k] <= pitem[k];
        rem_q[k]  <= rem_step(prem[k], pitem[k].position[PW-1-k*DB -: DB], rows_i);
      end
    end
  end

  assign en[NST]    = !a_v_q || out_ready_i;
  assign in_ready_o = en[0];

  assign rows_m1 = rows_i - CNT_W'(1);

  always_comb begin
    if (!item_q[NST-1].beyond) begin
      row = item_q[NST-1].position[ROW_W-1:0];
    end else if (wrap_i) begin
      row = rem_q[NST-1][ROW_W-1:0];
    end else begin
      row = rows_m1[ROW_W-1:0];
    end
    a_addr_d = ADDR_W'(row) * PAIRS_C + ADDR_W'(item_q[NST-1].pair_index);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en[NST]) begin
      a_v_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST] && v_q[NST-1]) begin
      a_item_q <= item_q[NST-1];
      a_addr_q <= a_addr_d;
    end
  end

  assign out_valid_o = a_v_q;
  assign out_item_o  = a_item_q;
  assign out_addr_o  = a_addr_q;

endmodule

`default_nettype wire

[hw/rtl/rpr_rotate.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpr_rotate (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire rpr_pkg::item_t                      in_item_i,
  input  wire logic        [rpr_pkg::VAL_W-1:0]    cos_i,
  input  wire logic        [rpr_pkg::VAL_W-1:0]    sin_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [rpr_pkg::VAL_W-1:0]    rotated_first_o,
  output logic signed      [rpr_pkg::VAL_W-1:0]    rotated_second_o,
  output logic                                     saturated_o,
  output logic                                     index_error_o
);

  localparam int unsigned VW = rpr_pkg::VAL_W;
  localparam int unsigned PW = 2 * VW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QW = SW + 1 - rpr_pkg::FRAC_W;

  localparam logic signed [SW:0] HALF_C = (SW + 1)'(1 << (rpr_pkg::FRAC_W - 1));
  localparam logic signed [QW-1:0] QMAX_C = QW'((1 << (VW - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN_C = -QW'(1 << (VW - 1));

  // {clip flag, value}
  function automatic logic [VW:0] round_sat(input logic signed [SW-1:0] sum);
    logic signed [SW:0]   v;
    logic signed [QW-1:0] q;
    logic [VW:0]          r;
    v = (SW + 1)'(sum) + HALF_C;
    q = QW'(v >>> rpr_pkg::FRAC_W);
    if (q > QMAX_C) begin
      r = {1'b1, QMAX_C[VW-1:0]};
    end else if (q < QMIN_C) begin
      r = {1'b1, QMIN_C[VW-1:0]};
    end else begin
      r = {1'b0, q[VW-1:0]};
    end
    return r;
  endfunction

  logic                 en_m;
  logic                 en_r;
  logic                 m_v_q;
  logic                 m_zero_q;
  logic                 m_err_q;
  logic signed [PW-1:0] p0_q;
  logic signed [PW-1:0] p1_q;
  logic signed [PW-1:0] p2_q;
  logic signed [PW-1:0] p3_q;
  logic                 r_v_q;

  logic signed [SW-1:0] sum0;
  logic signed [SW-1:0] sum1;
  logic [VW:0]          res0;
  logic [VW:0]          res1;

  assign en_r       = !r_v_q || !out_stall_i;
  assign en_m       = !m_v_q || en_r;
  assign in_ready_o = en_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      r_v_q <= 1'b0;
    end else begin
      if (en_m) begin
        m_v_q <= in_valid_i;
      end
      if (en_r) begin
        r_v_q <= m_v_q;
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (en_m && in_valid_i) begin
      p0_q     <= $signed(in_item_i.first_value) * $signed(cos_i);
      p1_q     <= $signed(in_item_i.second_value) * $signed(sin_i);
      p2_q     <= $signed(in_item_i.first_value) * $signed(sin_i);
      p3_q     <= $signed(in_item_i.second_value) * $signed(cos_i);
      m_zero_q <= (in_item_i.req_type == rpr_pkg::REQ_WRITE) || in_item_i.err;
      m_err_q  <= in_item_i.err;
    end
  end

  always_comb begin
    sum0 = SW'(p0_q) - SW'(p1_q);
    sum1 = SW'(p2_q) + SW'(p3_q);
    res0 = round_sat(sum0);
    res1 = round_sat(sum1);
  end

  // round and saturate, or zero for write and error beats, and hold the result beat
  always_ff @(posedge clk_i) begin
    if (en_r && m_v_q) begin
      if (m_zero_q) begin
        rotated_first_o  <= '0;
        rotated_second_o <= '0;
        saturated_o      <= 1'b0;
      end else begin
        rotated_first_o  <= res0[VW-1:0];
        rotated_second_o <= res1[VW-1:0];
        saturated_o      <= res0[VW] || res1[VW];
      end
      index_error_o <= m_err_q;
    end
  end

  assign out_valid_o = r_v_q;

endmodule

`default_nettype wire

[hw/rtl/rotary_position_rotate_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o       | req_type, position, pair_index, values
// out      | out_valid_o / out_stall_i     | rotated_first, rotated_second, flags
// cfg      | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one beat per cycle in and out while out_stall_i does not hold the pipeline
// path: input register, the four-stage position remainder pipeline, table read and multiply
// stages move on their own valid bits, so bubbles close up under output stall
// reset clears valids and sets config to its reset values; table contents hold whatever was last loaded

module rotary_position_rotate_top #(
  parameter int unsigned MAX_POSITIONS = rpr_pkg::MAX_POSITIONS,
  parameter int unsigned MAX_PAIRS     = rpr_pkg::MAX_PAIRS,
  localparam int unsigned CNT_W  = $clog2(MAX_POSITIONS + 1),
  localparam int unsigned PCNT_W = $clog2(MAX_PAIRS + 1),
  localparam int unsigned DEPTH  = MAX_POSITIONS * MAX_PAIRS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  req_type_i,
  input  wire logic        [rpr_pkg::POS_W-1:0]      position_i,
  input  wire logic        [rpr_pkg::PAIR_W-1:0]     pair_index_i,
  input  wire logic signed [rpr_pkg::VAL_W-1:0]      first_value_i,
  input  wire logic signed [rpr_pkg::VAL_W-1:0]      second_value_i,
  input  wire logic signed [rpr_pkg::VAL_W-1:0]      cos_value_i,
  input  wire logic signed [rpr_pkg::VAL_W-1:0]      sin_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed      [rpr_pkg::VAL_W-1:0]      rotated_first_o,
  output logic signed      [rpr_pkg::VAL_W-1:0]      rotated_second_o,
  output logic                                       saturated_o,
  output logic                                       index_error_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic        [rpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic        [rpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned VW = rpr_pkg::VAL_W;
  localparam int unsigned ROWS_RST_I =
      (MAX_POSITIONS < rpr_pkg::ROWS_RESET) ? MAX_POSITIONS : rpr_pkg::ROWS_RESET;
  localparam int unsigned PAIRS_RST_I =
      (MAX_PAIRS < rpr_pkg::PAIRS_RESET) ? MAX_PAIRS : rpr_pkg::PAIRS_RESET;
  localparam logic [CNT_W-1:0]  ROWS_RST  = CNT_W'(ROWS_RST_I);
  localparam logic [PCNT_W-1:0] PAIRS_RST = PCNT_W'(PAIRS_RST_I);

  // configuration
  logic [CNT_W-1:0]  rows_q;
  logic [CNT_W-1:0]  rows_d;
  logic [PCNT_W-1:0] pairs_q;
  logic [PCNT_W-1:0] pairs_d;
  logic              wrap_q;
  logic              cfg_we;
  logic [rpr_pkg::PAIRS_FIELD_W-1:0] pairs_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign pairs_raw   = cfg_data_i[rpr_pkg::PAIRS_FIELD_W-1:0];

  always_comb begin
    if (cfg_data_i == '0) begin
      rows_d = CNT_W'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_POSITIONS)) begin
      rows_d = CNT_W'(MAX_POSITIONS);
    end else begin
      rows_d = CNT_W'(cfg_data_i);
    end
    if (pairs_raw == '0) begin
      pairs_d = PCNT_W'(1);
    end else if (32'(pairs_raw) > 32'(MAX_PAIRS)) begin
      pairs_d = PCNT_W'(MAX_PAIRS);
    end else begin
      pairs_d = PCNT_W'(pairs_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_RST;
      pairs_q <= PAIRS_RST;
      wrap_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (rpr_pkg::cfg_idx_e'(cfg_index_i))
        rpr_pkg::CFG_TABLE_ROWS:   rows_q  <= rows_d;
        rpr_pkg::CFG_ACTIVE_PAIRS: pairs_q <= pairs_d;
        rpr_pkg::CFG_WRAP_MODE:    wrap_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register with range checks
  logic           s0_v_q;
  rpr_pkg::item_t s0_item_q;
  rpr_pkg::item_t s0_item_d;
  logic           s0_en;
  logic           map_ready;
  logic           beyond;
  logic           pair_bad;

  assign beyond   = 32'(position_i) >= 32'(rows_q);
  assign pair_bad = 32'(pair_index_i) >= 32'(pairs_q);

  always_comb begin
    s0_item_d.req_type     = rpr_pkg::req_e'(req_type_i);
    s0_item_d.position     = position_i;
    s0_item_d.pair_index   = pair_index_i;
    s0_item_d.first_value  = first_value_i;
    s0_item_d.second_value = second_value_i;
    s0_item_d.cos_value    = cos_value_i;
    s0_item_d.sin_value    = sin_value_i;
    s0_item_d.beyond       = beyond;
    s0_item_d.err          = pair_bad ||
                             ((rpr_pkg::req_e'(req_type_i) == rpr_pkg::REQ_WRITE) && beyond);
  end

  assign s0_en      = !s0_v_q || map_ready;
  assign in_stall_o = !s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_en && in_valid_i) begin
      s0_item_q <= s0_item_d;
    end
  end

  // row mapping and table address
  logic              a_v;
  rpr_pkg::item_t    a_item;
  logic [ADDR_W-1:0] a_addr;
  logic              b_en;

  rpr_row_map #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_PAIRS     (MAX_PAIRS)
  ) u_row_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_q),
    .wrap_i      (wrap_q),
    .in_valid_i  (s0_v_q),
    .in_ready_o  (map_ready),
    .in_item_i   (s0_item_q),
    .out_valid_o (a_v),
    .out_ready_i (b_en),
    .out_item_o  (a_item),
    .out_addr_o  (a_addr)
  );

  // table read stage
  logic           b_v_q;
  rpr_pkg::item_t b_item_q;
  logic           rot_ready;
  logic           ram_we;
  logic [2*VW-1:0] ram_rd_data;

  assign b_en   = !b_v_q || rot_ready;
  assign ram_we = b_en && a_v && (a_item.req_type == rpr_pkg::REQ_WRITE) && !a_item.err;

  rpr_ram #(
    .WIDTH (2 * VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (a_addr),
    .wr_data_i ({a_item.cos_value, a_item.sin_value}),
    .rd_en_i   (b_en),
    .rd_addr_i (a_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_en) begin
      b_v_q <= a_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en && a_v) begin
      b_item_q <= a_item;
    end
  end

  rpr_rotate u_rotate (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (b_v_q),
    .in_ready_o       (rot_ready),
    .in_item_i        (b_item_q),
    .cos_i            (ram_rd_data[2*VW-1:VW]),
    .sin_i            (ram_rd_data[VW-1:0]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rotated_first_o  (rotated_first_o),
    .rotated_second_o (rotated_second_o),
    .saturated_o      (saturated_o),
    .index_error_o    (index_error_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |->
      rotated_first_o == '0 && rotated_second_o == '0 && !saturated_o)
    else $error("error beat carries nonzero result");

  a_sat_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> !index_error_o)
    else $error("clip flagged on an error beat");

  a_we_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> 32'(a_addr) < 32'(DEPTH) && !a_item.beyond)
    else $error("table write outside the active rows");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rotated_first_o)
      && $stable(rotated_second_o))
    else $error("stalled result beat changed");
`endif

endmodule

`default_nettype wire
